/* src/signed_int_to_decimal_ascii_defines.svh */
// Assertion macros used by the top-level RTL of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDTA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIDTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/sidta_pkg.sv */
`timescale 1ns / 1ps

package sidta_pkg;

  localparam int NumDigits = 10;
  localparam int ValueWidth = 32;

  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

/* src/sidta_bcd_cell.sv */
`timescale 1ns / 1ps

module sidta_bcd_cell (
  input  logic                   clk,
  input  sidta_pkg::cell_ctrl_t  ctrl,
  input  logic                   bit_in,
  output sidta_pkg::digit_t      digit,
  output logic                   carry
);

  sidta_pkg::digit_t adj;

  // Add three to a digit of five or more so that the shift carries into the next decade.
  always_comb begin
    adj = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  end

  assign carry = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit <= 4'd0;
    end else if (ctrl.shift) begin
      digit <= {adj[2:0], bit_in};
    end
  end

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// After an input beat is accepted, its 32-bit magnitude is shifted into the chain of ten BCD
// digit cells, and then its N characters (N from 1 to 11) are sent; src_stall holds off the next
// item until the last character of the current one has been loaded.
// Characters then leave at one beat per cycle while the output is not stalled.
// Reset (rst, synchronous, active high) returns the block to idle with no output pending.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic signed [31:0] value,
  output logic        dst_valid,
  input  logic        dst_stall,
  output logic [7:0]  char_code,
  output logic [3:0]  total_chars,
  output logic        last
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam int N = sidta_pkg::NumDigits;

  logic [1:0]  state;
  logic [31:0] mag;
  logic        neg;
  logic [4:0]  cnt;
  logic [3:0]  pos;

  sidta_pkg::cell_ctrl_t ctrl;
  sidta_pkg::digit_t     digits [N];
  logic [N-2:0]          carries;

  logic       accept;
  logic       load;
  logic [3:0] ndig;
  logic [3:0] total_w;
  logic [3:0] idx;
  logic       is_last;
  logic [7:0] char_w;

  assign src_stall = (state != StIdle);
  assign accept = src_valid && !src_stall;
  assign load = (state == StEmit) && (!dst_valid || !dst_stall);

  assign ctrl.clr = accept;
  assign ctrl.shift = (state == StConv);

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        sidta_bcd_cell u_cell (
          .clk    (clk),
          .ctrl   (ctrl),
          .bit_in (mag[31]),
          .digit  (digits[gi]),
          .carry  (carries[gi])
        );
      end else if (gi < N - 1) begin : g_mid
        sidta_bcd_cell u_cell (
          .clk    (clk),
          .ctrl   (ctrl),
          .bit_in (carries[gi-1]),
          .digit  (digits[gi]),
          .carry  (carries[gi])
        );
      end else begin : g_top
        sidta_bcd_cell u_cell (
          .clk    (clk),
          .ctrl   (ctrl),
          .bit_in (carries[gi-1]),
          .digit  (digits[gi]),
          .carry  ()
        );
      end
    end
  endgenerate

  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < N; i++) begin
      if (digits[i] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  assign total_w = ndig + {3'd0, neg};
  assign idx = total_w - 4'd1 - pos;
  assign is_last = (pos == total_w - 4'd1);

  always_comb begin
    if (neg && (pos == 4'd0)) begin
      char_w = sidta_pkg::AsciiMinus;
    end else begin
      char_w = sidta_pkg::AsciiZero + {4'd0, digits[idx]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      dst_valid <= 1'b0;
      cnt <= 5'd0;
      pos <= 4'd0;
    end else begin
      if (dst_valid && !dst_stall && !load) begin
        dst_valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (accept) begin
            neg <= value[31];
            mag <= value[31] ? (32'd0 - value) : value;
            cnt <= 5'd0;
            state <= StConv;
          end
        end
        StConv: begin
          mag <= {mag[30:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            pos <= 4'd0;
            state <= StEmit;
          end
        end
        StEmit: begin
          if (load) begin
            dst_valid <= 1'b1;
            char_code <= char_w;
            total_chars <= total_w;
            last <= is_last;
            pos <= pos + 4'd1;
            if (is_last) begin
              state <= StIdle;
            end
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

  `SIDTA_ASSERT_SAME(a_minus_not_last, dst_valid && (char_code == sidta_pkg::AsciiMinus), !last && (total_chars >= 4'd2), "minus sign must open a run of two or more characters")
  `SIDTA_ASSERT_SAME(a_total_range, dst_valid, (total_chars >= 4'd1) && (total_chars <= 4'd11), "character count out of range")
  `SIDTA_ASSERT_NEXT(a_conv_done, (state == StConv) && (cnt == 5'd31), state == StEmit, "conversion did not end after 32 shifts")
  `SIDTA_ASSERT_NEXT(a_last_idle, load && is_last, (state == StIdle) && dst_valid && last, "final character did not return the block to idle")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 60;
  localparam int HoldOffCycles = 400;
  localparam int ItemsPerPhase = 90;
  localparam int NumDirected = 21;

  localparam logic [31:0] DirectedValues [NumDirected] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
    -32'sd1000000000, -32'sd999999999, 32'd123456789, -32'sd123456789, 32'd5,
    -32'sd7, 32'h5555_5555, 32'hAAAA_AAAA
  };

  typedef struct {
    logic [7:0] code;
    logic [3:0] total;
    logic       is_last;
  } char_beat_t;

  class digit_scoreboard;
    char_beat_t pending_chars[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Expands one accepted integer into the characters of its decimal text.
    function void note_value(logic [31:0] raw);
      logic [31:0] mag;
      logic [3:0]  digits [sidta_pkg::NumDigits];
      int          ndig;
      logic [3:0]  total;
      char_beat_t  beat;
      mag = raw[31] ? (32'd0 - raw) : raw;
      ndig = 0;
      do begin
        digits[ndig] = 4'(mag % 32'd10);
        mag = mag / 32'd10;
        ndig++;
      end while (mag != 32'd0 && ndig < sidta_pkg::NumDigits);
      total = 4'(ndig + (raw[31] ? 1 : 0));
      if (raw[31]) begin
        beat.code = sidta_pkg::AsciiMinus;
        beat.total = total;
        beat.is_last = 1'b0;
        pending_chars.push_back(beat);
      end
      for (int k = ndig - 1; k >= 0; k--) begin
        beat.code = sidta_pkg::AsciiZero + 8'(digits[k]);
        beat.total = total;
        beat.is_last = (k == 0);
        pending_chars.push_back(beat);
      end
    endfunction

    function void check_char(logic [7:0] code, logic [3:0] total, logic is_last);
      char_beat_t beat;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: code %0d total %0d last %0d", code, total, is_last);
      end else begin
        beat = pending_chars.pop_front();
        if (code !== beat.code || total !== beat.total || is_last !== beat.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected code %0d total %0d last %0d, got %0d %0d %0d",
                     beat.code, beat.total, beat.is_last, code, total, is_last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [31:0] value = 32'd0;
  logic        dst_valid;
  logic        dst_stall = 1'b0;
  logic [7:0]  char_code;
  logic [3:0]  total_chars;
  logic        last;

  digit_scoreboard sb;
  int src_idle_pct = 0;
  int dst_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  signed_int_to_decimal_ascii u_top (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .value      (value),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .char_code  (char_code),
    .total_chars(total_chars),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) sb.note_value(value);
      if (dst_valid && !dst_stall) sb.check_char(char_code, total_chars, last);
    end
  end

  // The long hold-off keeps the output stalled so that the block backs up onto its input.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      dst_stall <= 1'b1;
      repeat (hold_cycles) @(posedge clk);
      hold_cycles = 0;
    end else begin
      dst_stall <= ($urandom_range(99) < dst_stall_pct);
    end
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(7))
      0: v = $urandom_range(9);
      1: v = $urandom_range(999);
      2: v = $urandom_range(999999);
      3: begin
        v = 32'd1;
        repeat ($urandom_range(9)) v = v * 32'd10;
        v = v + 32'($urandom_range(2)) - 32'd1;
      end
      4: v = 32'h7FFF_FFFF - 32'($urandom_range(3));
      default: ;
    endcase
    if (v[31] == 1'b0 && $urandom_range(1) == 1) v = 32'd0 - v;
    return v;
  endfunction

  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (src_stall !== 1'b0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    src_idle_pct = idle_pct;
    dst_stall_pct = stall_pct;
    repeat (count) send_value(pick_value());
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NumDirected; i++) send_value(DirectedValues[i]);
    run_phase(0, 0, ItemsPerPhase);
    run_phase(81, 0, ItemsPerPhase);
    run_phase(0, 81, ItemsPerPhase);
    run_phase(15, 15, ItemsPerPhase);
    hold_cycles = HoldOffCycles;
    run_phase(0, 0, ItemsPerPhase);
    src_valid <= 1'b0;
    dst_stall_pct = 0;
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
